[sv/pic_pkg.sv]
`default_nettype none

package pic_pkg;

  // Number of interrupt lines held in the mask, status and ack registers.
  localparam int NUM_LINES = 32;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_ACK   = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam logic [3:0] REG_MASK       = 4'd0;
  localparam logic [3:0] REG_MASK_SET   = 4'd1;
  localparam logic [3:0] REG_MASK_CLR   = 4'd2;
  localparam logic [3:0] REG_STATUS     = 4'd3;
  localparam logic [3:0] REG_STATUS_SET = 4'd4;
  localparam logic [3:0] REG_STATUS_CLR = 4'd5;
  localparam logic [3:0] REG_ACK        = 4'd6;
  localparam logic [3:0] REG_ACK_SET    = 4'd7;
  localparam logic [3:0] REG_ACK_CLR    = 4'd8;
  localparam logic [3:0] REG_FIFO       = 4'd9;

  localparam logic [3:0] GOOD_SIZE = 4'd4;

  localparam logic RESP_OK      = 1'b0;
  localparam logic RESP_INVALID = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  reg_select;
    logic [3:0]  access_size;
    logic [31:0] wdata;
    logic [4:0]  ack_line;
  } pic_in_t;

  typedef struct packed {
    logic        resp_status;
    logic [31:0] rdata;
    logic        irq_pending;
    logic [4:0]  irq_line;
    logic        irq_update;
  } pic_out_t;

  typedef struct packed {
    logic        resp_status;
    logic [31:0] rdata;
  } pic_bus_rsp_t;

endpackage

`default_nettype wire

[sv/pic_regs.sv]
`default_nettype none

module pic_regs (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            en,
  input  pic_pkg::pic_in_t               item,
  output pic_pkg::pic_bus_rsp_t          rsp,
  output logic [pic_pkg::NUM_LINES-1:0]  pend_nxt
);

  logic [pic_pkg::NUM_LINES-1:0] mask_r, mask_nxt;
  logic [pic_pkg::NUM_LINES-1:0] status_r, status_nxt;
  logic [pic_pkg::NUM_LINES-1:0] ack_r, ack_nxt;
  logic [pic_pkg::NUM_LINES-1:0] d;
  logic [pic_pkg::NUM_LINES-1:0] line_bit;
  logic                          wr;

  assign d        = item.wdata[pic_pkg::NUM_LINES-1:0];
  assign line_bit = {{(pic_pkg::NUM_LINES-1){1'b0}}, 1'b1} << item.ack_line;
  assign wr       = (item.action == pic_pkg::ACT_WRITE);

  always_comb begin
    mask_nxt        = mask_r;
    status_nxt      = status_r;
    ack_nxt         = ack_r;
    rsp.resp_status = pic_pkg::RESP_OK;
    rsp.rdata       = 32'd0;
    if (item.action == pic_pkg::ACT_READ || item.action == pic_pkg::ACT_WRITE) begin
      if (item.access_size != pic_pkg::GOOD_SIZE) begin
        rsp.resp_status = pic_pkg::RESP_INVALID;
      end else begin
        case (item.reg_select)
          pic_pkg::REG_MASK: begin
            if (wr) mask_nxt = d;
            else rsp.rdata = 32'(mask_r);
          end
          pic_pkg::REG_MASK_SET: begin
            if (wr) mask_nxt = mask_r | d;
            else rsp.resp_status = pic_pkg::RESP_INVALID;
          end
          pic_pkg::REG_MASK_CLR: begin
            if (wr) mask_nxt = mask_r & ~d;
            else rsp.resp_status = pic_pkg::RESP_INVALID;
          end
          pic_pkg::REG_STATUS: begin
            if (wr) status_nxt = d;
            else rsp.rdata = 32'(status_r);
          end
          pic_pkg::REG_STATUS_SET: begin
            if (wr) status_nxt = status_r | d;
            else rsp.resp_status = pic_pkg::RESP_INVALID;
          end
          pic_pkg::REG_STATUS_CLR: begin
            if (wr) status_nxt = status_r & ~d;
            else rsp.resp_status = pic_pkg::RESP_INVALID;
          end
          pic_pkg::REG_ACK: begin
            if (wr) ack_nxt = d;
            else rsp.rdata = 32'(ack_r);
          end
          pic_pkg::REG_ACK_SET: begin
            if (wr) ack_nxt = ack_r | d;
            else rsp.resp_status = pic_pkg::RESP_INVALID;
          end
          pic_pkg::REG_ACK_CLR: begin
            if (wr) ack_nxt = ack_r & ~d;
            else rsp.resp_status = pic_pkg::RESP_INVALID;
          end
          pic_pkg::REG_FIFO: begin
            // The event FIFO is never filled: reads give zero, writes are refused.
            if (wr) rsp.resp_status = pic_pkg::RESP_INVALID;
          end
          default: begin
          end
        endcase
      end
    end else if (item.action == pic_pkg::ACT_ACK) begin
      // A line number beyond the implemented lines leaves everything alone.
      if (int'(item.ack_line) < pic_pkg::NUM_LINES) begin
        status_nxt = status_r & ~line_bit;
        ack_nxt    = ack_r | line_bit;
      end
    end
  end

  assign pend_nxt = status_nxt & mask_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      status_r <= '0;
      ack_r    <= '0;
    end else if (en) begin
      mask_r   <= mask_nxt;
      status_r <= status_nxt;
      ack_r    <= ack_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/pic_prio.sv]
`default_nettype none

module pic_prio (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  wire [pic_pkg::NUM_LINES-1:0]  pend,
  output logic                          irq_pending,
  output logic [4:0]                    irq_line,
  output logic                          irq_update
);

  logic       last_valid_r;
  logic [4:0] last_line_r;

  always_comb begin
    irq_line = 5'd0;
    for (int i = 0; i < pic_pkg::NUM_LINES; i++) begin
      if (pend[i]) irq_line = 5'(i);
    end
  end

  assign irq_pending = |pend;
  assign irq_update  = (irq_pending != last_valid_r) ||
                       (irq_pending && (irq_line != last_line_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_valid_r <= 1'b0;
      last_line_r  <= 5'd0;
    end else if (en) begin
      last_valid_r <= irq_pending;
      last_line_r  <= irq_line;
    end
  end

endmodule

`default_nettype wire

[sv/priority_interrupt_controller.sv]
// Interrupt controller with mask, status and ack registers, 32 lines.
// Input channel (in_valid/in_ready/in_data): one bus read, bus write or
// acknowledge from the core per transfer.
// Output channel (out_valid/out_ready/out_data): exactly one result per
// input item, in order: bus response, read data, and the highest-numbered
// pending unmasked line with a flag set when that request changed.
// From input transfer to result valid, the item is captured in an input
// register, then the register update and the priority encoder run in one
// pass and load the result register.
// Throughput is one item per cycle while the receiver takes results.
// When the receiver stalls, the result register holds its value and one
// further item waits in the input register; in_ready drops only when both
// are full.
// Synchronous reset clears the mask, status and ack registers and the last
// request (no request) and leaves both channels empty.
`default_nettype none

module priority_interrupt_controller (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  pic_pkg::pic_in_t  in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output pic_pkg::pic_out_t out_data
);

  pic_pkg::pic_in_t      item_r;
  logic                  item_valid_r;
  pic_pkg::pic_out_t     res_r, res_nxt;
  logic                  res_valid_r;
  logic                  advance;
  pic_pkg::pic_bus_rsp_t rsp;
  logic [pic_pkg::NUM_LINES-1:0] pend_nxt;
  logic                  irq_pending;
  logic [4:0]            irq_line;
  logic                  irq_update;

  // The held item moves on whenever the result register is free or being emptied.
  assign advance  = item_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  pic_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .item     (item_r),
    .rsp      (rsp),
    .pend_nxt (pend_nxt)
  );

  pic_prio u_prio (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .pend        (pend_nxt),
    .irq_pending (irq_pending),
    .irq_line    (irq_line),
    .irq_update  (irq_update)
  );

  always_comb begin
    res_nxt.resp_status = rsp.resp_status;
    res_nxt.rdata       = rsp.rdata;
    res_nxt.irq_pending = irq_pending;
    res_nxt.irq_line    = irq_line;
    res_nxt.irq_update  = irq_update;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      if (in_ready) item_valid_r <= in_valid;
      if (advance) res_valid_r <= 1'b1;
      else if (out_ready) res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) item_r <= in_data;
    if (advance) res_r <= res_nxt;
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

endmodule

`default_nettype wire
